### rtl/pbfb_pkg.sv
`timescale 1ns / 1ps

package pbfb_pkg;

    // command codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SQUARE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam int PAL_ENTRIES = 8;
    localparam int PAL_IDX_W   = 3;
    localparam int RGB_W       = 16;
    localparam int MAX_ADDR_W  = 16;
    localparam int COORD_W     = 13;
    localparam int APB_ADDR_W  = 5;

    localparam logic [RGB_W-1:0] PAL_RESET [PAL_ENTRIES] = '{
        16'd2177, 16'd3840, 16'd19816, 16'd24393,
        16'd51199, 16'd64201, 16'd64648, 16'd65451
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] color;
        logic [3:0] scale;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] rgb565;
        logic [2:0]  color_index;
        logic        in_range;
    } rsp_item_t;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [MAX_ADDR_W-1:0] addr;
        logic [PAL_IDX_W-1:0]  data;
    } mem_req_t;

endpackage

### rtl/pbfb_store.sv
`timescale 1ns / 1ps

module pbfb_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                            clk,
    input  pbfb_pkg::mem_req_t              req,
    output logic [pbfb_pkg::PAL_IDX_W-1:0]  rd_data
);

    logic [pbfb_pkg::PAL_IDX_W-1:0] mem [DEPTH];
    logic [pbfb_pkg::PAL_IDX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.en && req.we)
        begin
            mem[req.addr[ADDR_W-1:0]] <= req.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.en && !req.we)
        begin
            rd_data_reg <= mem[req.addr[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/pbfb_palette.sv
`timescale 1ns / 1ps

module pbfb_palette (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbfb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic [pbfb_pkg::PAL_IDX_W-1:0]      lookup_idx,
    output logic [pbfb_pkg::RGB_W-1:0]          lookup_rgb
);

    logic [pbfb_pkg::RGB_W-1:0]     pal_reg [pbfb_pkg::PAL_ENTRIES];
    logic [pbfb_pkg::PAL_IDX_W-1:0] reg_sel;

    assign reg_sel = paddr[pbfb_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbfb_pkg::PAL_ENTRIES; i++)
            begin
                pal_reg[i] <= pbfb_pkg::PAL_RESET[i];
            end
        end
        else if (psel && penable && pwrite)
        begin
            pal_reg[reg_sel] <= pwdata[pbfb_pkg::RGB_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = {16'd0, pal_reg[reg_sel]};
    assign lookup_rgb = pal_reg[lookup_idx];

endmodule

### rtl/pbfb_seq.sv
`timescale 1ns / 1ps

module pbfb_seq #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128,
    parameter int MAX_SCALE    = 8,
    parameter int ADDR_W       = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  pbfb_pkg::cmd_item_t     cmd,
    output logic                    idle,
    output pbfb_pkg::mem_req_t      mem_req
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CLEAR  = 2'd1;
    localparam logic [1:0] ST_SQUARE = 2'd2;

    localparam int CW = pbfb_pkg::COORD_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_WIDTH * FRAME_HEIGHT - 1);

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]        color_reg, color_next;
    logic [CW-1:0]     bx_reg, bx_next, by_reg, by_next;
    logic [3:0]        col_reg, col_next, row_reg, row_next;
    logic [3:0]        last_reg, last_next;

    logic [3:0]    side;
    logic          cmd_inside;
    logic [16:0]   cmd_addr;
    logic [CW-1:0] px, py;
    logic          sq_inside;
    logic [16:0]   sq_addr;

    assign side = ({1'b0, cmd.scale} > 5'(MAX_SCALE)) ? 4'(MAX_SCALE) : cmd.scale;

    assign cmd_inside = ({1'b0, cmd.x} < 9'(FRAME_WIDTH)) && ({1'b0, cmd.y} < 9'(FRAME_HEIGHT));
    assign cmd_addr   = 17'(cmd.y) * 17'(FRAME_WIDTH) + 17'(cmd.x);

    // each pixel of the square is clipped on its own
    assign px        = bx_reg + CW'(col_reg);
    assign py        = by_reg + CW'(row_reg);
    assign sq_inside = (px < CW'(FRAME_WIDTH)) && (py < CW'(FRAME_HEIGHT));
    assign sq_addr   = 17'(py[7:0]) * 17'(FRAME_WIDTH) + 17'(px[7:0]);

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        color_next    = color_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        last_next     = last_reg;
        mem_req       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        pbfb_pkg::OP_CLEAR:
                        begin
                            state_next    = ST_CLEAR;
                            clr_addr_next = '0;
                            color_next    = cmd.color;
                        end
                        pbfb_pkg::OP_WRITE:
                        begin
                            mem_req.en   = cmd_inside;
                            mem_req.we   = 1'b1;
                            mem_req.addr = pbfb_pkg::MAX_ADDR_W'(cmd_addr[ADDR_W-1:0]);
                            mem_req.data = cmd.color;
                        end
                        pbfb_pkg::OP_SQUARE:
                        begin
                            if (side != 4'd0)
                            begin
                                state_next = ST_SQUARE;
                            end
                            color_next = cmd.color;
                            bx_next    = CW'(cmd.x) * CW'(side);
                            by_next    = CW'(cmd.y) * CW'(side);
                            col_next   = '0;
                            row_next   = '0;
                            last_next  = side - 4'd1;
                        end
                        pbfb_pkg::OP_READ:
                        begin
                            mem_req.en   = cmd_inside;
                            mem_req.we   = 1'b0;
                            mem_req.addr = pbfb_pkg::MAX_ADDR_W'(cmd_addr[ADDR_W-1:0]);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = pbfb_pkg::MAX_ADDR_W'(clr_addr_reg);
                mem_req.data  = color_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQUARE:
            begin
                mem_req.en   = sq_inside;
                mem_req.we   = 1'b1;
                mem_req.addr = pbfb_pkg::MAX_ADDR_W'(sq_addr[ADDR_W-1:0]);
                mem_req.data = color_reg;
                if (col_reg == last_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + 4'd1;
                    if (row_reg == last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts a clearing pass with index zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            color_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            color_reg    <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        last_reg <= last_next;
    end

endmodule

### rtl/palettized_bitplane_framebuffer_unit.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// cmd      | cmd_valid/cmd_ready  | cmd (op, x, y, color, scale)
// rsp      | rsp_valid/rsp_ready  | rsp (rgb565, color_index, in_range)
// apb      | psel/penable/pready  | paddr, pwdata, prdata (palette 0..7)
//
// pixel writes and reads take one item per cycle unless a stalled result holds them back;
// a read result is registered in the memory output register, then in the response register
// (the palette lookup between them is combinational); a clear sets up, then writes every pixel
// a scaled square sets up, then covers a side*side block (side = scale capped at MAX_SCALE)
// after reset a clearing pass over the whole frame runs before
// the first item is taken; a stalled result holds back items once a read waits behind it

module palettized_bitplane_framebuffer_unit #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128,
    parameter int MAX_SCALE    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  pbfb_pkg::cmd_item_t                 cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output pbfb_pkg::rsp_item_t                 rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbfb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                            accept;
    logic                            seq_idle;
    pbfb_pkg::mem_req_t              mem_req;
    logic [pbfb_pkg::PAL_IDX_W-1:0]  rd_data;
    logic [pbfb_pkg::RGB_W-1:0]      pal_rgb;

    logic                rd_pend_reg, rd_pend_next;
    logic                rd_inr_reg, rd_inr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    pbfb_pkg::rsp_item_t rsp_reg, rsp_next;
    logic                stall;
    logic                advance;
    logic                accept_read;

    assign stall     = rd_pend_reg && rsp_valid_reg && !rsp_ready;
    assign advance   = rd_pend_reg && !stall;
    assign cmd_ready = seq_idle && !stall;
    assign accept    = cmd_valid && cmd_ready;
    assign accept_read = accept && (cmd.op == pbfb_pkg::OP_READ);

    pbfb_seq #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .MAX_SCALE    (MAX_SCALE),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .idle    (seq_idle),
        .mem_req (mem_req)
    );

    pbfb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    pbfb_palette u_palette (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .lookup_idx (rd_data),
        .lookup_rgb (pal_rgb)
    );

    always_comb
    begin
        rd_pend_next   = accept_read || (rd_pend_reg && stall);
        rd_inr_next    = accept_read ? mem_req.en : rd_inr_reg;
        rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);
        rsp_next       = rsp_reg;
        if (advance)
        begin
            rsp_next.in_range    = rd_inr_reg;
            rsp_next.color_index = rd_inr_reg ? rd_data : '0;
            rsp_next.rgb565      = rd_inr_reg ? pal_rgb : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_inr_reg <= rd_inr_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a memory read always leaves a read waiting for the output stage
    a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.en && !mem_req.we |=> rd_pend_reg)
        else $error("memory read without pending result");

    // a stalled read keeps its data in the memory output register
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> rd_pend_reg && $stable(rd_data) && $stable(rd_inr_reg))
        else $error("stalled read lost its data");

    // nothing touches the store while a read is stalled
    a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !mem_req.en)
        else $error("memory access during stalled read");

    // an out-of-frame read carries zeros
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.in_range |-> rsp.rgb565 == '0 && rsp.color_index == '0)
        else $error("outside read with nonzero payload");
`endif

endmodule
